// ===== design/mandelbrot_smooth_pixel_defines.svh =====
// Assertion macros for the smooth Mandelbrot pixel block.
`ifndef MANDELBROT_SMOOTH_PIXEL_DEFINES_SVH
`define MANDELBROT_SMOOTH_PIXEL_DEFINES_SVH

// Check on aclk, ignored while aresetn is low.
`define MSP_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("msp check failed");

// Check on aclk, also sampled during reset.
`define MSP_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("msp reset check failed");

`endif

// ===== design/msp_pkg.sv =====
package msp_pkg;

    localparam int WIDTH_DEF    = 1920;
    localparam int HEIGHT_DEF   = 1080;
    localparam int MAX_ITER_DEF = 16;

    localparam int Q_W      = 36;
    localparam int FRAC_W   = 24;
    localparam int SUM_W    = 38;
    localparam int COORD_W  = 12;
    localparam int MAG_W    = 13;
    localparam int COUNT_W  = 11;
    localparam int FRAME_W  = 10;
    localparam int GREY_W   = 8;
    localparam int QUO_W    = 37;

    localparam int LOG_STEPS = 16;
    localparam int MANT_W    = 31;
    localparam int LFRAC_W   = 16;
    localparam int EXP_W     = 6;
    localparam int SH_W      = 6;

    localparam int MAP_SCALE = 100;
    localparam int MAP_DEN   = 85;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic signed [Q_W-1:0] ONE_Q = Q_W'(1) <<< FRAC_W;

    // grey mapping: d = c - 2.5 (Q16); grey = floor(d*1275/32768/11)
    localparam int C_BIAS  = 163840;
    localparam int D_SAT   = 72090;
    localparam int T_MUL   = 1275;
    localparam int R_MUL   = 5957;
    localparam int R_DIV   = 11;
    localparam logic [GREY_W-1:0] GREY_MAX = '1;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } pix_in_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [COUNT_W-1:0] iteration_count;
        logic               escaped;
        logic [GREY_W-1:0]  intensity;
    } pix_out_t;

    typedef struct packed {
        logic               valid;
        logic [MANT_W-1:0]  mant;
        logic [LFRAC_W-1:0] frac;
        logic [EXP_W-1:0]   expo;
    } log_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MAP, ST_DIVS, ST_DIV, ST_MUL1, ST_MUL2, ST_STEP,
        ST_CHK, ST_NRM, ST_LOG, ST_G1, ST_G2, ST_G3, ST_OUT
    } state_t;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(Q_MAX);
        lo = SUM_W'(Q_MIN);
        if (v > hi) return Q_MAX;
        if (v < lo) return Q_MIN;
        return v[Q_W-1:0];
    endfunction

    // apply sign to an unsigned quotient, saturating to the Q range
    function automatic logic signed [Q_W-1:0] sign_sat(input logic neg, input logic over,
                                                       input logic [QUO_W-1:0] q);
        logic [Q_W-1:0] m;
        m = q[Q_W-1:0];
        if (!neg) begin
            if (over || q > QUO_W'(Q_MAX)) return Q_MAX;
            return $signed(m);
        end
        if (over || q > (QUO_W'(1) << (Q_W-1))) return Q_MIN;
        return $signed(Q_W'(0) - m);
    endfunction

endpackage

// ===== design/mandelbrot_smooth_pixel.sv =====
// Smooth-colored Mandelbrot pixel engine.
// Input channel (s_valid/s_ready/s_data) takes one pixel coordinate per
// request; the result channel (m_valid/m_ready/m_data) returns the same
// coordinate with its iteration count, escape flag and 8-bit grey level.
// cfg_wr_en/cfg_wr_data write the frame index (escape threshold 4 + index)
// at once; write it only while no pixel is in flight.
// One pixel is worked on at a time. After a request is accepted, the
// coordinate is mapped to c through two reciprocal dividers (four 32x32
// partial products each); each iteration of z = z*z + c then runs through
// the three 2-stage multipliers (up to MAX_ITERATIONS iterations); when
// |z|^2 ends above 1, normalizing and up to two passes through a 16-cell
// chain of squaring cells give log2(log2(|z|^2)), followed by grey scaling
// in states ST_G1 to ST_G3. The next request can be taken in the cycle
// after the result is loaded. s_ready is high only while no pixel is in
// progress. The result sits in an output register, so a new request is
// taken while an earlier result waits for m_ready; a stalled receiver
// holds the engine only once the next result is done.
// Synchronous active-low reset clears the control state and the frame index.
module mandelbrot_smooth_pixel #(
    parameter int WIDTH          = msp_pkg::WIDTH_DEF,
    parameter int HEIGHT         = msp_pkg::HEIGHT_DEF,
    parameter int MAX_ITERATIONS = msp_pkg::MAX_ITER_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  msp_pkg::pix_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output msp_pkg::pix_out_t                m_data,
    input  logic                             cfg_wr_en,
    input  logic [msp_pkg::FRAME_W-1:0]      cfg_wr_data
);

    localparam int QW      = msp_pkg::Q_W;
    localparam int SW      = msp_pkg::SUM_W;
    localparam int CW      = msp_pkg::COUNT_W;
    localparam int MAGW    = msp_pkg::MAG_W;
    localparam int FW      = msp_pkg::FRAC_W;
    localparam int LFW     = msp_pkg::LFRAC_W;
    localparam int EW      = msp_pkg::EXP_W;
    localparam int SHW     = msp_pkg::SH_W;
    localparam int NSTEP   = msp_pkg::LOG_STEPS;
    localparam int RSCALE  = WIDTH * msp_pkg::MAP_SCALE;
    localparam int RSCALE_W = $clog2(RSCALE + 1);
    localparam int ISCALE_W = $clog2(msp_pkg::MAP_SCALE + 1);
    localparam int NUMR_W  = MAGW + RSCALE_W + FW;
    localparam int NUMI_W  = MAGW + ISCALE_W + FW;
    localparam logic [63:0] DEN_R = 64'(WIDTH - 1) * 64'(HEIGHT) * 64'(msp_pkg::MAP_DEN);
    localparam logic [63:0] DEN_I = 64'(HEIGHT - 1) * 64'(msp_pkg::MAP_DEN);
    localparam int L1_W    = 4 + LFW;
    localparam int C_W     = EW + LFW;
    localparam int D_W     = C_W + 1;

    msp_pkg::state_t state_reg, state_next;

    logic [msp_pkg::FRAME_W-1:0] frame_reg;
    logic [msp_pkg::COORD_W-1:0] px_reg, px_next, py_reg, py_next;
    logic [NUMR_W-1:0] numr_reg, numr_next;
    logic [NUMI_W-1:0] numi_reg, numi_next;
    logic              negr_reg, negr_next, negi_reg, negi_next;
    logic signed [QW-1:0] cr_reg, cr_next, ci_reg, ci_next;
    logic signed [QW-1:0] zr_reg, zr_next, zi_reg, zi_next;
    logic signed [QW-1:0] norm_reg, norm_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              esc_reg, esc_next;
    logic [QW-1:0]     v_reg, v_next;
    logic [SHW-1:0]    sh_reg, sh_next;
    logic              pass_reg, pass_next;
    logic signed [D_W-1:0] d_reg, d_next;
    logic [11:0]       t_reg, t_next;
    logic [7:0]        q_reg, q_next;
    logic [msp_pkg::GREY_W-1:0] grey_reg, grey_next;
    logic              m_valid_reg, m_valid_next;
    msp_pkg::pix_out_t m_data_reg, m_data_next;

    logic signed [MAGW:0] nx, ny;
    logic [MAGW-1:0]      mag_x, mag_y;
    logic                 div_start;
    logic                 r_done, r_over, i_done, i_over;
    logic [msp_pkg::QUO_W-1:0] r_quo, i_quo;
    logic signed [QW-1:0] rr, ii, ri;
    logic signed [SW-1:0] sum_re, sum_im, sum_n;
    logic signed [QW-1:0] norm_new, cr_new, ci_new;
    logic signed [QW-1:0] thr;
    logic [CW-1:0]        thr_int;
    logic [L1_W-1:0]      l1;
    logic signed [C_W-1:0] c_log;
    logic [27:0]          t_prod;
    logic [24:0]          q_prod;
    logic [11:0]          rem_t;
    msp_pkg::log_t        chain [NSTEP+1];

    assign nx = $signed({1'b0, px_reg, 1'b0}) - (MAGW+1)'(WIDTH - 1);
    assign ny = $signed({1'b0, py_reg, 1'b0}) - (MAGW+1)'(HEIGHT - 1);
    assign mag_x = nx[MAGW] ? MAGW'(-nx) : MAGW'(nx);
    assign mag_y = ny[MAGW] ? MAGW'(-ny) : MAGW'(ny);

    msp_div #(.NUM_W(NUMR_W), .DEN(DEN_R)) u_div_r (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(numr_reg),
        .done(r_done), .over(r_over), .quo(r_quo)
    );

    msp_div #(.NUM_W(NUMI_W), .DEN(DEN_I)) u_div_i (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(numi_reg),
        .done(i_done), .over(i_over), .quo(i_quo)
    );

    msp_qmul u_mul_rr (.aclk(aclk), .a(zr_reg), .b(zr_reg), .p(rr));
    msp_qmul u_mul_ii (.aclk(aclk), .a(zi_reg), .b(zi_reg), .p(ii));
    msp_qmul u_mul_ri (.aclk(aclk), .a(zr_reg), .b(zi_reg), .p(ri));

    assign sum_re   = SW'(rr) - SW'(ii) + SW'(cr_reg);
    assign sum_im   = SW'(ri) + SW'(ri) + SW'(ci_reg);
    assign sum_n    = SW'(rr) + SW'(ii);
    assign norm_new = msp_pkg::sat_q(sum_n);
    assign cr_new   = msp_pkg::sign_sat(negr_reg, r_over, r_quo);
    assign ci_new   = msp_pkg::sign_sat(negi_reg, i_over, i_quo);
    assign thr_int  = CW'(frame_reg) + CW'(4);
    assign thr      = $signed({1'b0, thr_int, {FW{1'b0}}});

    // log2 chain: cell k emits fraction bit LFRAC_W-1-k of the mantissa's log (MSB first)
    assign chain[0].valid = (state_reg == msp_pkg::ST_NRM) && v_reg[QW-1];
    assign chain[0].mant  = v_reg[QW-1:QW-msp_pkg::MANT_W];
    assign chain[0].frac  = '0;
    assign chain[0].expo  = EW'(QW - 1) - EW'(sh_reg);

    for (genvar k = 0; k < NSTEP; k++) begin : g_log
        msp_log_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .cell_in(chain[k]), .cell_out(chain[k+1])
        );
    end

    assign l1    = {4'(chain[NSTEP].expo - EW'(FW)), chain[NSTEP].frac};
    assign c_log = $signed({EW'(chain[NSTEP].expo - EW'(LFW)), chain[NSTEP].frac});
    assign t_prod = 28'(d_reg[16:0]) * 28'(msp_pkg::T_MUL);
    assign q_prod = 25'(t_reg) * 25'(msp_pkg::R_MUL);
    assign rem_t  = t_reg - 12'(q_reg) * 12'(msp_pkg::R_DIV);

    always_comb begin
        state_next   = state_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        numr_next    = numr_reg;
        numi_next    = numi_reg;
        negr_next    = negr_reg;
        negi_next    = negi_reg;
        cr_next      = cr_reg;
        ci_next      = ci_reg;
        zr_next      = zr_reg;
        zi_next      = zi_reg;
        norm_next    = norm_reg;
        count_next   = count_reg;
        esc_next     = esc_reg;
        v_next       = v_reg;
        sh_next      = sh_reg;
        pass_next    = pass_reg;
        d_next       = d_reg;
        t_next       = t_reg;
        q_next       = q_reg;
        grey_next    = grey_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            msp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    px_next    = s_data.pixel_x;
                    py_next    = s_data.pixel_y;
                    state_next = msp_pkg::ST_MAP;
                end
            end
            msp_pkg::ST_MAP: begin
                numr_next  = {(MAGW+RSCALE_W)'(mag_x) * (MAGW+RSCALE_W)'(RSCALE), {FW{1'b0}}};
                numi_next  = {(MAGW+ISCALE_W)'(mag_y) * (MAGW+ISCALE_W)'(msp_pkg::MAP_SCALE),
                              {FW{1'b0}}};
                negr_next  = nx[MAGW];
                negi_next  = ny[MAGW];
                count_next = '0;
                esc_next   = 1'b0;
                grey_next  = '0;
                state_next = msp_pkg::ST_DIVS;
            end
            msp_pkg::ST_DIVS: begin
                div_start  = 1'b1;
                state_next = msp_pkg::ST_DIV;
            end
            msp_pkg::ST_DIV: begin
                if (r_done && i_done) begin
                    cr_next    = cr_new;
                    ci_next    = ci_new;
                    // first iteration from z = 0 gives z = c
                    zr_next    = cr_new;
                    zi_next    = ci_new;
                    state_next = msp_pkg::ST_MUL1;
                end
            end
            msp_pkg::ST_MUL1: state_next = msp_pkg::ST_MUL2;
            msp_pkg::ST_MUL2: state_next = msp_pkg::ST_STEP;
            msp_pkg::ST_STEP: begin
                norm_next = norm_new;
                if (norm_new >= thr) begin
                    esc_next   = 1'b1;
                    state_next = msp_pkg::ST_CHK;
                end else if (count_reg == CW'(MAX_ITERATIONS - 1)) begin
                    count_next = CW'(MAX_ITERATIONS);
                    state_next = msp_pkg::ST_CHK;
                end else begin
                    zr_next    = msp_pkg::sat_q(sum_re);
                    zi_next    = msp_pkg::sat_q(sum_im);
                    count_next = count_reg + CW'(1);
                    state_next = msp_pkg::ST_MUL1;
                end
            end
            msp_pkg::ST_CHK: begin
                if (norm_reg > msp_pkg::ONE_Q) begin
                    v_next     = QW'(norm_reg);
                    sh_next    = '0;
                    pass_next  = 1'b0;
                    state_next = msp_pkg::ST_NRM;
                end else begin
                    state_next = msp_pkg::ST_OUT;
                end
            end
            msp_pkg::ST_NRM: begin
                // bring the leading one to the top, eight places or one at a time
                if (v_reg[QW-1:QW-8] == 8'd0) begin
                    v_next  = v_reg << 8;
                    sh_next = sh_reg + SHW'(8);
                end else if (!v_reg[QW-1]) begin
                    v_next  = v_reg << 1;
                    sh_next = sh_reg + SHW'(1);
                end else begin
                    state_next = msp_pkg::ST_LOG;
                end
            end
            msp_pkg::ST_LOG: begin
                if (chain[NSTEP].valid) begin
                    if (!pass_reg) begin
                        if (l1 == '0) begin
                            state_next = msp_pkg::ST_OUT;
                        end else begin
                            v_next     = QW'(l1);
                            sh_next    = '0;
                            pass_next  = 1'b1;
                            state_next = msp_pkg::ST_NRM;
                        end
                    end else begin
                        d_next     = D_W'(c_log) - D_W'(msp_pkg::C_BIAS);
                        state_next = msp_pkg::ST_G1;
                    end
                end
            end
            msp_pkg::ST_G1: begin
                if (d_reg <= 0) begin
                    state_next = msp_pkg::ST_OUT;
                end else if (d_reg >= D_W'(msp_pkg::D_SAT)) begin
                    grey_next  = msp_pkg::GREY_MAX;
                    state_next = msp_pkg::ST_OUT;
                end else begin
                    t_next     = t_prod[26:15];
                    state_next = msp_pkg::ST_G2;
                end
            end
            msp_pkg::ST_G2: begin
                q_next     = q_prod[23:16];
                state_next = msp_pkg::ST_G3;
            end
            msp_pkg::ST_G3: begin
                grey_next  = (rem_t >= 12'(msp_pkg::R_DIV)) ? q_reg + 8'd1 : q_reg;
                state_next = msp_pkg::ST_OUT;
            end
            msp_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.out_x           = px_reg;
                    m_data_next.out_y           = py_reg;
                    m_data_next.iteration_count = count_reg;
                    m_data_next.escaped         = esc_reg;
                    m_data_next.intensity       = grey_reg;
                    state_next                  = msp_pkg::ST_IDLE;
                end
            end
            default: state_next = msp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= msp_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            frame_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                frame_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        numr_reg   <= numr_next;
        numi_reg   <= numi_next;
        negr_reg   <= negr_next;
        negi_reg   <= negi_next;
        cr_reg     <= cr_next;
        ci_reg     <= ci_next;
        zr_reg     <= zr_next;
        zi_reg     <= zi_next;
        norm_reg   <= norm_next;
        count_reg  <= count_next;
        esc_reg    <= esc_next;
        v_reg      <= v_next;
        sh_reg     <= sh_next;
        pass_reg   <= pass_next;
        d_reg      <= d_next;
        t_reg      <= t_next;
        q_reg      <= q_next;
        grey_reg   <= grey_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == msp_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/msp_qmul.sv =====
module msp_qmul (
    input  logic                            aclk,
    input  logic signed [msp_pkg::Q_W-1:0]  a,
    input  logic signed [msp_pkg::Q_W-1:0]  b,
    output logic signed [msp_pkg::Q_W-1:0]  p
);

    localparam int QW = msp_pkg::Q_W;
    localparam int HW = QW / 2;

    logic [QW-1:0]   ua;
    logic [QW-1:0]   ub;
    logic [QW-1:0]   hh_reg, hl_reg, lh_reg, ll_reg;
    logic            neg_reg;
    logic [2*QW-1:0] full;
    logic [2*QW-msp_pkg::FRAC_W-1:0] mag;
    logic signed [QW-1:0] p_next;
    logic signed [QW-1:0] p_reg;

    assign ua = a[QW-1] ? QW'(0) - QW'(a) : QW'(a);
    assign ub = b[QW-1] ? QW'(0) - QW'(b) : QW'(b);

    always_ff @(posedge aclk) begin
        hh_reg  <= ua[QW-1:HW] * ub[QW-1:HW];
        hl_reg  <= ua[QW-1:HW] * ub[HW-1:0];
        lh_reg  <= ua[HW-1:0] * ub[QW-1:HW];
        ll_reg  <= ua[HW-1:0] * ub[HW-1:0];
        neg_reg <= a[QW-1] ^ b[QW-1];
    end

    assign full = {hh_reg, {QW{1'b0}}}
                + ((2*QW)'(hl_reg) << HW) + ((2*QW)'(lh_reg) << HW)
                + (2*QW)'(ll_reg);
    assign mag = full[2*QW-1:msp_pkg::FRAC_W];

    always_comb begin
        if (!neg_reg) begin
            p_next = (mag > $bits(mag)'(msp_pkg::Q_MAX)) ? msp_pkg::Q_MAX
                                                         : $signed(mag[QW-1:0]);
        end else if (mag > ($bits(mag)'(1) << (QW-1))) begin
            p_next = msp_pkg::Q_MIN;
        end else begin
            p_next = $signed(QW'(0) - mag[QW-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// ===== design/msp_div.sv =====
module msp_div #(
    parameter int          NUM_W = 64,
    parameter logic [63:0] DEN   = 64'd1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [NUM_W-1:0]            num,
    output logic                        done,
    output logic                        over,
    output logic [msp_pkg::QUO_W-1:0]   quo
);

    localparam int QW   = msp_pkg::QUO_W;
    localparam int CH   = 32;
    localparam int SH   = NUM_W + $clog2(DEN);
    localparam int RW   = NUM_W + 2;
    localparam int NA   = (NUM_W + CH - 1) / CH;
    localparam int NB   = (RW + CH - 1) / CH;
    localparam int AW   = CH * (NA + NB) + QW;
    localparam int IA_W = $clog2(NA + 1);
    localparam int IB_W = $clog2(NB + 1);
    // ceil(2^SH / DEN): exact floor division for every NUM_W-bit numerator
    localparam logic [127:0] RECIP = ((128'd1 << SH) + 128'(DEN) - 128'd1) / 128'(DEN);

    logic [CH*NA-1:0] num_reg, num_next;
    logic [CH*NB-1:0] rcp;
    logic [AW-1:0]    acc_reg, acc_next;
    logic [IA_W-1:0]  ia_reg, ia_next;
    logic [IB_W-1:0]  ib_reg, ib_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CH-1:0]    a_part;
    logic [CH-1:0]    b_part;
    logic [2*CH-1:0]  pp;
    logic [AW-1:0]    quot;

    assign rcp    = (CH*NB)'(RECIP);
    assign a_part = num_reg[ia_reg*CH +: CH];
    assign b_part = rcp[ib_reg*CH +: CH];
    assign pp     = (2*CH)'(a_part) * (2*CH)'(b_part);
    assign quot   = acc_reg >> SH;

    always_comb begin
        num_next  = num_reg;
        acc_next  = acc_reg;
        ia_next   = ia_reg;
        ib_next   = ib_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            num_next  = (CH*NA)'(num);
            acc_next  = '0;
            ia_next   = '0;
            ib_next   = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            // one 32x32 partial product per cycle
            acc_next = acc_reg + (AW'(pp) << (CH * (32'(ia_reg) + 32'(ib_reg))));
            if (ib_reg == IB_W'(NB - 1)) begin
                ib_next = '0;
                if (ia_reg == IA_W'(NA - 1)) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end else begin
                    ia_next = ia_reg + IA_W'(1);
                end
            end else begin
                ib_next = ib_reg + IB_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        acc_reg <= acc_next;
        ia_reg  <= ia_next;
        ib_reg  <= ib_next;
    end

    assign done = done_reg;
    assign over = |quot[AW-1:QW];
    assign quo  = quot[QW-1:0];

endmodule

// ===== design/msp_log_cell.sv =====
module msp_log_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  msp_pkg::log_t        cell_in,
    output msp_pkg::log_t        cell_out
);

    localparam int MW = msp_pkg::MANT_W;

    logic [2*MW-1:0] sq;
    logic [MW:0]     sq_top;
    msp_pkg::log_t   cell_reg, cell_next;

    // square the mantissa in [1,2); renormalize and emit one fraction bit
    assign sq     = cell_in.mant * cell_in.mant;
    assign sq_top = sq[2*MW-1:MW-1];

    always_comb begin
        cell_next       = cell_in;
        cell_next.mant  = sq_top[MW] ? sq_top[MW:1] : sq_top[MW-1:0];
        cell_next.frac  = {cell_in.frac[msp_pkg::LFRAC_W-2:0], sq_top[MW]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg <= '0;
        end else begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ===== design/msp_checker.sv =====
`include "mandelbrot_smooth_pixel_defines.svh"

module msp_checker #(
    parameter int MAX_ITERATIONS = msp_pkg::MAX_ITER_DEF
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input msp_pkg::pix_in_t             s_data,
    input logic                         m_valid,
    input logic                         m_ready,
    input msp_pkg::pix_out_t            m_data,
    input logic                         cfg_wr_en,
    input logic [msp_pkg::FRAME_W-1:0]  cfg_wr_data
);

    localparam logic [msp_pkg::COUNT_W-1:0] CNT_MAX = msp_pkg::COUNT_W'(MAX_ITERATIONS);

    `MSP_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data))
    `MSP_ASSERT_RST(a_reset_clears, !aresetn |=> !m_valid)
    `MSP_ASSERT(a_esc_count, m_valid |-> (m_data.escaped != (m_data.iteration_count == CNT_MAX)))
    `MSP_ASSERT(a_busy_after_req, s_valid && s_ready |=> !s_ready)
    `MSP_ASSERT(a_result_when_busy, $rose(m_valid) |-> !$past(s_ready))

endmodule

bind mandelbrot_smooth_pixel msp_checker #(.MAX_ITERATIONS(MAX_ITERATIONS)) u_msp_checker (.*);

// ===== tb/sv/tb_mandelbrot_smooth_pixel.sv =====
module tb_mandelbrot_smooth_pixel;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = msp_pkg::WIDTH_DEF;
    localparam int H = msp_pkg::HEIGHT_DEF;
    localparam int NITER = msp_pkg::MAX_ITER_DEF;
    localparam longint QMX = 64'sd34359738367;
    localparam longint QMN = -64'sd34359738368;
    localparam longint ONE = 64'sd1 << 24;
    localparam int CYCLE_LIMIT = 2000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    msp_pkg::pix_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    msp_pkg::pix_out_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [msp_pkg::FRAME_W-1:0] cfg_wr_data = '0;

    logic [msp_pkg::FRAME_W-1:0] frame_idx = '0;
    msp_pkg::pix_out_t pending_pixels[$];
    int errors = 0;
    int pixels_checked = 0;
    int escaped_seen = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    mandelbrot_smooth_pixel dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint sat36(longint v);
        if (v > QMX) return QMX;
        if (v < QMN) return QMN;
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        logic neg;
        longint unsigned ua, ub, ah, al, bh, bl, p;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        ah = ua >> 24; al = ua & 64'hFFFFFF;
        bh = ub >> 24; bl = ub & 64'hFFFFFF;
        p = ((ah * bh) << 24) + ah * bl + al * bh + ((al * bl) >> 24);
        if (p > (64'd1 << 35)) p = 64'd1 << 35;
        return sat36(neg ? -longint'(p) : longint'(p));
    endfunction

    // log2 by repeated squaring of the normalized mantissa, Q16 result
    function automatic longint log2_q16(longint unsigned v, int fb);
        int msb;
        longint unsigned m;
        longint fr;
        msb = 63;
        fr = 0;
        while (msb > 0 && v[msb] == 1'b0) msb--;
        m = msb >= 30 ? v >> (msb - 30) : v << (30 - msb);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            fr = fr << 1;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                fr = fr | 1;
            end
        end
        return longint'(msb - fb) * 65536 + fr;
    endfunction

    function automatic msp_pkg::pix_out_t shade_pixel(msp_pkg::pix_in_t p);
        msp_pkg::pix_out_t r;
        longint nx, ny, cr, ci, zr, zi, nrm, thr, rr, ii, ri, l1, c, num, g;
        nx = 2 * longint'(p.pixel_x) - (W - 1);
        ny = 2 * longint'(p.pixel_y) - (H - 1);
        cr = sat36(nx * W * ONE * 100 / (longint'(W - 1) * H * 85));
        ci = sat36(ny * ONE * 100 / (longint'(H - 1) * 85));
        zr = 0; zi = 0; nrm = 0;
        thr = (4 + longint'(frame_idx)) * ONE;
        r = '0;
        r.out_x = p.pixel_x;
        r.out_y = p.pixel_y;
        r.iteration_count = msp_pkg::COUNT_W'(NITER);
        for (int it = 0; it < NITER; it++) begin
            rr = fx_mul(zr, zr); ii = fx_mul(zi, zi); ri = fx_mul(zr, zi);
            zr = sat36(rr - ii + cr);
            zi = sat36(2 * ri + ci);
            nrm = sat36(fx_mul(zr, zr) + fx_mul(zi, zi));
            if (nrm >= thr) begin
                r.iteration_count = msp_pkg::COUNT_W'(it);
                r.escaped = 1'b1;
                break;
            end
        end
        if (nrm > ONE) begin
            l1 = log2_q16(nrm, 24);
            if (l1 > 0) begin
                c = log2_q16(l1, 16);
                num = (c - msp_pkg::C_BIAS) * 2550;
                if (num > 0) begin
                    g = num / (longint'(11) * 65536);
                    r.intensity = g > 255 ? msp_pkg::GREY_MAX : msp_pkg::GREY_W'(g);
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    // hold valid after a request so back-to-back requests need no gap
    task automatic send_pixel(int x, int y);
        msp_pkg::pix_in_t p;
        p.pixel_x = msp_pkg::COORD_W'(x);
        p.pixel_y = msp_pkg::COORD_W'(y);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_pixels.push_back(shade_pixel(p));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_frame(int v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= msp_pkg::FRAME_W'(v);
        frame_idx = msp_pkg::FRAME_W'(v);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // checker: compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        msp_pkg::pix_out_t want;
        cycles <= cycles + 1;
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected result x", m_data.out_x, -1);
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (want.escaped) escaped_seen++;
                if (m_data.out_x !== want.out_x)
                    report_mismatch("out_x", m_data.out_x, want.out_x);
                if (m_data.out_y !== want.out_y)
                    report_mismatch("out_y", m_data.out_y, want.out_y);
                if (m_data.iteration_count !== want.iteration_count)
                    report_mismatch("iteration_count", m_data.iteration_count,
                                    want.iteration_count);
                if (m_data.escaped !== want.escaped)
                    report_mismatch("escaped", m_data.escaped, want.escaped);
                if (m_data.intensity !== want.intensity)
                    report_mismatch("intensity", m_data.intensity, want.intensity);
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    task automatic test_corners();
        send_pixel(0, 0);
        send_pixel(W - 1, H - 1);
        send_pixel(4095, 4095);
        send_pixel(4095, 0);
        send_pixel(0, 4095);
        send_pixel(2730, 2730);
        send_pixel(1365, 1365);
        send_pixel(W / 2, H / 2);     // near origin: small magnitude, grey 0
        send_pixel(W / 2 - 200, H / 2);
        send_pixel(W / 2 + 300, H / 2 + 150);
        send_pixel(W / 3, H / 4);
    endtask

    task automatic test_frame_extremes();
        write_frame(1023);
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(W / 2, H / 2);
        write_frame(0);
        send_pixel(100, 900);
        send_pixel(1800, 100);
    endtask

    task automatic test_random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0)
                send_pixel($urandom_range(4095), $urandom_range(4095));
            else
                send_pixel($urandom_range(W - 1), $urandom_range(H - 1));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_corners();
        test_frame_extremes();
        test_random_phase(320, 0, 0);
        write_frame($urandom_range(1, 20));
        test_random_phase(320, 46, 0);
        write_frame($urandom_range(1023));
        test_random_phase(320, 0, 46);
        write_frame(0);
        test_random_phase(320, 18, 18);
        drain();
        $display("checked %0d pixels, %0d escaped, over several frame indexes and stall mixes",
                 pixels_checked, escaped_seen);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/msp_pkg.sv
design/msp_qmul.sv
design/msp_div.sv
design/msp_log_cell.sv
design/mandelbrot_smooth_pixel.sv
design/msp_checker.sv
tb/sv/tb_mandelbrot_smooth_pixel.sv
